[src/sfnv_pkg.sv]
// Package for the seeded FNV-1a 64 hash with fmix64 finaliser.
// Holds the hash constants, the sequencer state type, the multiplier
// request/response structs and the xor-shift step. No dependencies.
`default_nettype none

package sfnv_pkg;

    localparam int unsigned HASH_W  = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned MIX_SHIFT = 33;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [HASH_W-1:0] FNV_PRIME = 64'h00000100000001b3;
    localparam logic [HASH_W-1:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
    localparam logic [HASH_W-1:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FNV_GO,
        ST_FNV_WAIT,
        ST_MIXA_GO,
        ST_MIXA_WAIT,
        ST_MIXB_GO,
        ST_MIXB_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] prod;
    } t_mul_rsp;

    function automatic logic [HASH_W-1:0] xor_shift(input logic [HASH_W-1:0] h);
        return h ^ (h >> MIX_SHIFT);
    endfunction

endpackage

`default_nettype wire

[src/seeded_fnv1a64_with_mix_finalizer.sv]
// Top level: seeded FNV-1a 64 stream hash with fmix64 finaliser.
// Sequencer and hash state around the shared multiplier. Depends on
// sfnv_pkg and sfnv_mul.
//
//  channel   dir  beat contents
//  s_axis    in   tdata[7:0] data_byte, tuser[0] byte_present, tlast end_of_message
//  m_axis    out  tdata[63:0] digest
//  cfg       in   wen/wdata[63:0] hash_seed
//
// Byte beat without tlast: accept, launch, then three multiplier passes. A beat with
// tlast adds the finaliser (two multiplies); an empty closing beat runs the finaliser
// alone. Each multiply runs the three passes of the 3-pass 32 x 32 multiplier.
// s_axis is accepted only while the sequencer is idle; a finished digest waits
// in the output register and stalls the sequencer only if still untaken.
// Reset is synchronous, active low, seed 0; no clearing pass.
`default_nettype none

module seeded_fnv1a64_with_mix_finalizer
    import sfnv_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [BYTE_W-1:0] i_s_axis_tdata,  // [7:0] data_byte
    input  wire logic              i_s_axis_tuser,  // [0] byte_present
    input  wire logic              i_s_axis_tlast,
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [HASH_W-1:0]      o_m_axis_tdata,  // [63:0] digest
    input  wire logic              i_cfg_wen,
    input  wire logic [HASH_W-1:0] i_cfg_wdata
);

    t_state            r_state;
    t_state            n_state;
    logic [HASH_W-1:0] r_seed;
    logic [HASH_W-1:0] r_hash;
    logic              r_idle;
    logic [HASH_W-1:0] r_work;
    logic              r_last;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_out_data;

    t_mul_req          w_req;
    t_mul_rsp          w_rsp;
    logic              w_take;
    logic              w_emit;
    logic              w_absorb_done;
    logic [HASH_W-1:0] w_h0;
    logic [HASH_W-1:0] w_h1;

    sfnv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_h0 = r_idle ? (FNV_BASIS ^ r_seed) : r_hash;
    assign w_h1 = i_s_axis_tuser ? (w_h0 ^ {{(HASH_W-BYTE_W){1'b0}}, i_s_axis_tdata}) : w_h0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    if (i_s_axis_tuser) begin
                        n_state = ST_FNV_GO;
                    end else if (i_s_axis_tlast) begin
                        n_state = ST_MIXA_GO;
                    end
                end
            end
            ST_FNV_GO:    n_state = ST_FNV_WAIT;
            ST_FNV_WAIT: begin
                if (w_rsp.done) begin
                    n_state = r_last ? ST_MIXA_GO : ST_IDLE;
                end
            end
            ST_MIXA_GO:   n_state = ST_MIXA_WAIT;
            ST_MIXA_WAIT: begin
                if (w_rsp.done) begin
                    n_state = ST_MIXB_GO;
                end
            end
            ST_MIXB_GO:   n_state = ST_MIXB_WAIT;
            ST_MIXB_WAIT: begin
                if (w_rsp.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        w_take          = (r_state == ST_IDLE) && i_s_axis_tvalid;
        w_emit          = (r_state == ST_EMIT) && (!r_out_valid || i_m_axis_tready);
        w_absorb_done   = (r_state == ST_FNV_WAIT) && w_rsp.done && !r_last;
        w_req.start     = (r_state == ST_FNV_GO) || (r_state == ST_MIXA_GO)
                          || (r_state == ST_MIXB_GO);
        w_req.a         = (r_state == ST_FNV_GO) ? r_work : xor_shift(r_work);
        unique case (r_state)
            ST_FNV_GO:  w_req.b = FNV_PRIME;
            ST_MIXA_GO: w_req.b = MIX_MUL_A;
            default:    w_req.b = MIX_MUL_B;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= '0;
            r_idle      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) begin
                r_seed <= i_cfg_wdata;
            end
            if (w_absorb_done) begin
                r_idle <= 1'b0;
            end else if (w_emit) begin
                r_idle <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_work <= w_h1;
            r_last <= i_s_axis_tlast;
        end else if (w_rsp.done) begin
            r_work <= w_rsp.prod;
        end
        if (w_absorb_done) begin
            r_hash <= w_rsp.prod;
        end
        if (w_emit) begin
            r_out_data <= xor_shift(r_work);
        end
    end

endmodule

`default_nettype wire

[src/sfnv_mul.sv]
// Shared 64 x 64 multiplier, product mod 2^64, built from one 32 x 32 unit.
// Three passes: low x low, low x high, high x low. Depends on sfnv_pkg.
`default_nettype none

module sfnv_mul
    import sfnv_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;

    logic              r_busy;
    logic [1:0]        r_step;
    logic [HASH_W-1:0] r_a;
    logic [HASH_W-1:0] r_b;
    logic [HASH_W-1:0] r_acc;
    logic [HASH_W-1:0] n_acc;
    logic [HALF_W-1:0] w_x;
    logic [HALF_W-1:0] w_y;
    logic [HASH_W-1:0] w_prod;

    always_comb begin
        w_x    = (r_step == STEP_HL) ? r_a[HASH_W-1:HALF_W] : r_a[HALF_W-1:0];
        w_y    = (r_step == STEP_LH) ? r_b[HASH_W-1:HALF_W] : r_b[HALF_W-1:0];
        w_prod = {{HALF_W{1'b0}}, w_x} * {{HALF_W{1'b0}}, w_y};
        case (r_step)
            STEP_LL: n_acc = w_prod;
            default: n_acc = {r_acc[HASH_W-1:HALF_W] + w_prod[HALF_W-1:0],
                              r_acc[HALF_W-1:0]};
        endcase
    end

    assign o_rsp.done = r_busy && (r_step == STEP_HL);
    assign o_rsp.prod = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_LL;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= STEP_LL;
        end else if (r_busy) begin
            if (r_step == STEP_HL) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        if (r_busy) begin
            r_acc <= n_acc;
        end
    end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for seeded_fnv1a64_with_mix_finalizer: byte beats are hashed
// by a local FNV-1a 64 / fmix64 predictor and each digest beat is compared in order.
// Depends on sfnv_pkg and the RTL under test only.
`default_nettype none

module tb_top;
    import sfnv_pkg::*;

    localparam int TIMEOUT_CYCLES = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_BEATS   = 580;
    localparam int MAX_REPORTS    = 10;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [BYTE_W-1:0] i_s_axis_tdata  = '0;   // [7:0] data_byte
    logic              i_s_axis_tuser  = 1'b0; // [0] byte_present
    logic              i_s_axis_tlast  = 1'b0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [HASH_W-1:0] o_m_axis_tdata;         // [63:0] digest
    logic              i_cfg_wen       = 1'b0;
    logic [HASH_W-1:0] i_cfg_wdata     = '0;

    logic [HASH_W-1:0] seed_reg;
    logic [HASH_W-1:0] msg_hash;
    bit                msg_open;
    logic [HASH_W-1:0] digest_q[$];

    int beat_count   = 0;
    int digest_count = 0;
    int err_count    = 0;
    int seed_writes  = 0;
    int holdoffs     = 0;
    int burst_left   = 0;
    bit hold_rx      = 1'b0;

    seeded_fnv1a64_with_mix_finalizer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [HASH_W-1:0] fmix64_finish(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] x;
        x = h ^ (h >> MIX_SHIFT);
        x = x * MIX_MUL_A;
        x = x ^ (x >> MIX_SHIFT);
        x = x * MIX_MUL_B;
        return x ^ (x >> MIX_SHIFT);
    endfunction

    function automatic void fold_beat(input logic [BYTE_W-1:0] b, input logic present,
                                      input logic last);
        logic [HASH_W-1:0] h;
        h = msg_open ? msg_hash : (FNV_BASIS ^ seed_reg);
        if (present) begin
            h = (h ^ {{(HASH_W-BYTE_W){1'b0}}, b}) * FNV_PRIME;
        end
        if (last) begin
            digest_q.push_back(fmix64_finish(h));
            msg_open = 1'b0;
        end else if (present) begin
            msg_hash = h;
            msg_open = 1'b1;
        end
        if (present || last) begin
            beat_count++;
        end
    endfunction

    function automatic logic [HASH_W-1:0] pick_seed();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic present,
                             input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= present;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        fold_beat(b, present, last);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [HASH_W-1:0] value);
        wait_drained();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        seed_reg = value;
        seed_writes++;
    endtask

    task automatic send_message(input int len, input bit reseed_mid);
        bit trailing;
        int i;
        trailing = (len == 0) || ($urandom_range(0, 3) == 0);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_beat(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_beat(BYTE_W'($urandom_range(0, 255)), 1'b1,
                      !trailing && (i == len - 1));
            if (reseed_mid && i == 0 && len > 1) begin
                write_seed(pick_seed());
            end
        end
        if (trailing) begin
            send_beat(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    task automatic test_directed_beats();
        send_beat(8'h5a, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'hc3, 1'b0, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h01, 1'b1, 1'b0);
        send_beat(8'h7f, 1'b1, 1'b1);
        send_beat(8'haa, 1'b0, 1'b0);
        send_beat(8'h55, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_seed_settings();
        write_seed('1);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        write_seed(64'h8000_0000_0000_0001);
        send_beat(8'h31, 1'b1, 1'b0);
        send_beat(8'h32, 1'b1, 1'b0);
        // change the seed with a message open: it keeps its start value
        write_seed('0);
        send_beat(8'h33, 1'b1, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        write_seed(64'h0123_4567_89ab_cdef);
        send_beat(8'h0f, 1'b1, 1'b0);
        send_beat(8'hf0, 1'b1, 1'b1);
        write_seed('1);
        send_beat(8'h00, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_receiver_holdoff();
        repeat (2) begin
            hold_rx = 1'b1;
            holdoffs++;
            repeat (10) send_message($urandom_range(0, 2), 1'b0);
            wait_drained();
        end
    endtask

    task automatic test_random_stream();
        int target;
        int msgs;
        int len;
        int r;
        target = beat_count + RANDOM_BEATS;
        msgs = 0;
        while (beat_count < target) begin
            if (msgs % 25 == 0) begin
                write_seed(pick_seed());
            end else if ($urandom_range(0, 39) == 0) begin
                wait_drained();
            end
            r = $urandom_range(0, 15);
            if (r == 0) begin
                len = 0;
            end else if (r == 1) begin
                len = $urandom_range(20, 48);
            end else begin
                len = $urandom_range(1, 6);
            end
            send_message(len, $urandom_range(0, 24) == 0);
            msgs++;
        end
        wait_drained();
    endtask

    initial begin : rx_side
        int run;
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_rx) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
                repeat (run) @(posedge i_clk);
                stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (stall != 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : digest_checker
        logic [HASH_W-1:0] want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                digest_count++;
                if (digest_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("unexpected digest beat %h", o_m_axis_tdata);
                    end
                end else begin
                    want = digest_q.pop_front();
                    if (o_m_axis_tdata !== want) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("digest mismatch: expected %h got %h",
                                     want, o_m_axis_tdata);
                        end
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < TIMEOUT_CYCLES) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin : main_seq
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        seed_reg = '0;
        msg_hash = FNV_BASIS;
        msg_open = 1'b0;
        test_directed_beats();
        test_seed_settings();
        test_receiver_holdoff();
        test_random_stream();
        $display("Run covered %0d hash beats, %0d digests and %0d seed writes,",
                 beat_count, digest_count, seed_writes);
        $display("with %0d long output hold-offs and random gaps on both sides.", holdoffs);
        if (err_count == 0 && digest_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
